>>> design/pcbc_pkg.sv
// Package for the clamped back-calculation PID controller.
// Holds the register map, reset values and the configuration struct.
// No dependencies; used by pcbc_regs and pid_clamped_back_calc.
package pcbc_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned INTEG_W = 32;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned ADDR_W  = 5;

	typedef enum logic [2:0] {
		REG_GAIN_P       = 3'd0,
		REG_GAIN_I       = 3'd1,
		REG_GAIN_D       = 3'd2,
		REG_LIMIT_LOW    = 3'd3,
		REG_LIMIT_HIGH   = 3'd4,
		REG_INTEG_PRESET = 3'd5
	} pcbc_reg_t;

	localparam logic signed [DATA_W-1:0] LIMIT_LOW_RST  = 16'sh8000;
	localparam logic signed [DATA_W-1:0] LIMIT_HIGH_RST = 16'sh7fff;

	typedef struct packed {
		logic signed [DATA_W-1:0]  gain_p;
		logic signed [DATA_W-1:0]  gain_i;
		logic signed [DATA_W-1:0]  gain_d;
		logic signed [DATA_W-1:0]  limit_low;
		logic signed [DATA_W-1:0]  limit_high;
		logic signed [INTEG_W-1:0] integ_preset;
	} pcbc_cfg_t;

endpackage

>>> design/pcbc_regs.sv
// APB-style configuration registers for the PID controller.
// Depends on pcbc_pkg for the register map and the configuration struct.
module pcbc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcbc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output pcbc_pkg::pcbc_cfg_t         cfg
);
	import pcbc_pkg::*;

	pcbc_cfg_t cfg_q;
	pcbc_reg_t reg_idx;
	logic      wr_en;

	assign reg_idx = pcbc_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.limit_low    <= LIMIT_LOW_RST;
			cfg_q.limit_high   <= LIMIT_HIGH_RST;
			cfg_q.integ_preset <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GAIN_P:       cfg_q.gain_p       <= pwdata[DATA_W-1:0];
				REG_GAIN_I:       cfg_q.gain_i       <= pwdata[DATA_W-1:0];
				REG_GAIN_D:       cfg_q.gain_d       <= pwdata[DATA_W-1:0];
				REG_LIMIT_LOW:    cfg_q.limit_low    <= pwdata[DATA_W-1:0];
				REG_LIMIT_HIGH:   cfg_q.limit_high   <= pwdata[DATA_W-1:0];
				REG_INTEG_PRESET: cfg_q.integ_preset <= pwdata[INTEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Sign-extend the narrow registers on read
	always_comb begin
		unique case (reg_idx)
			REG_GAIN_P:       prdata = 32'(cfg_q.gain_p);
			REG_GAIN_I:       prdata = 32'(cfg_q.gain_i);
			REG_GAIN_D:       prdata = 32'(cfg_q.gain_d);
			REG_LIMIT_LOW:    prdata = 32'(cfg_q.limit_low);
			REG_LIMIT_HIGH:   prdata = 32'(cfg_q.limit_high);
			REG_INTEG_PRESET: prdata = 32'(cfg_q.integ_preset);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> design/pid_clamped_back_calc.sv
// PID controller, trapezoidal integral, clamped output with back-calculated integrator.
// One item per cycle sustained while out_ready does not stall the output.
// Stage 1 registers error terms, stage 2 the products, stage 3 closes the integrator loop.
// An output stall holds each full stage; the input stalls once all three stages hold an item.
// Asynchronous active-low reset clears integrator, previous error, held output and gains.
// Depends on pcbc_pkg and pcbc_regs.
module pid_clamped_back_calc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pcbc_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pcbc_pkg::DATA_W-1:0] setpoint,
	input  logic signed [pcbc_pkg::DATA_W-1:0] measured,
	input  logic                               run,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pcbc_pkg::DATA_W-1:0] drive,
	output logic                               at_limit
);
	import pcbc_pkg::*;

	pcbc_cfg_t cfg;

	pcbc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic signed [DATA_W-1:0]  gain_p, gain_i, gain_d, limit_low, limit_high;
	logic signed [INTEG_W-1:0] integ_preset;

	assign gain_p       = cfg.gain_p;
	assign gain_i       = cfg.gain_i;
	assign gain_d       = cfg.gain_d;
	assign limit_low    = cfg.limit_low;
	assign limit_high   = cfg.limit_high;
	assign integ_preset = cfg.integ_preset;

	// Flow control
	logic v1_q, v2_q, out_valid_q;
	logic rdy1, rdy2, rdy3;

	assign rdy3      = !out_valid_q || out_ready;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) out_valid_q <= v2_q;
		end
	end

	// Stage 1: error, error difference and halved error sum
	logic signed [DATA_W-1:0] prev_q;
	logic signed [DATA_W-1:0] err_in, prev_eff, half_in;
	logic signed [DATA_W:0]   diff_in, sum_in;
	logic                     acc_in;

	assign acc_in   = in_valid && rdy1;
	assign err_in   = setpoint - measured;
	assign prev_eff = restart ? '0 : prev_q;
	assign diff_in  = {err_in[DATA_W-1], err_in} - {prev_eff[DATA_W-1], prev_eff};
	assign sum_in   = {err_in[DATA_W-1], err_in} + {prev_eff[DATA_W-1], prev_eff};
	assign half_in  = sum_in[DATA_W:1];

	// The previous error only moves on running items, so track it at the input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (acc_in && run) begin
			prev_q <= err_in;
		end
	end

	logic                     run_s1, restart_s1;
	logic signed [DATA_W-1:0] err_s1, half_s1;
	logic signed [DATA_W:0]   diff_s1;

	always_ff @(posedge clk) begin
		if (acc_in) begin
			run_s1     <= run;
			restart_s1 <= restart;
			err_s1     <= err_in;
			diff_s1    <= diff_in;
			half_s1    <= half_in;
		end
	end

	// Stage 2: products
	localparam int unsigned PD_W  = 2 * DATA_W + 2;
	localparam int unsigned SUM_W = PD_W + 1;
	localparam int unsigned RAW_W = SUM_W - FRAC_W;

	logic signed [2*DATA_W-1:0] prod_p, prod_i;
	logic signed [2*DATA_W:0]   prod_d;
	logic signed [PD_W-1:0]     pd_in;

	assign prod_p = (2*DATA_W)'(err_s1) * (2*DATA_W)'(gain_p);
	assign prod_d = (2*DATA_W+1)'(diff_s1) * (2*DATA_W+1)'(gain_d);
	assign prod_i = (2*DATA_W)'(half_s1) * (2*DATA_W)'(gain_i);
	assign pd_in  = PD_W'(prod_p) + PD_W'(prod_d);

	logic                      run_s2, restart_s2;
	logic signed [PD_W-1:0]    pd_s2;
	logic signed [INTEG_W-1:0] inc_s2;

	always_ff @(posedge clk) begin
		if (v1_q && rdy2) begin
			run_s2     <= run_s1;
			restart_s2 <= restart_s1;
			pd_s2      <= pd_in;
			inc_s2     <= INTEG_W'(prod_i);
		end
	end

	// Stage 3: integrator update, scale, clamp and back-calculation
	logic signed [INTEG_W-1:0]       integ_q, integ_base, integ_acc, integ_next;
	logic signed [SUM_W-1:0]         sum_all;
	logic signed [RAW_W-1:0]         raw;
	logic signed [DATA_W-1:0]        lim_sel, drive_q;
	logic signed [DATA_W+FRAC_W-1:0] lim_scaled;
	logic signed [PD_W-1:0]          back_calc;
	logic                            below, above, clamp, at_limit_q, load3;

	assign integ_base = restart_s2 ? integ_preset : integ_q;
	assign integ_acc  = integ_base + inc_s2;
	assign sum_all    = SUM_W'(pd_s2) + SUM_W'(integ_acc);
	assign raw        = sum_all[SUM_W-1:FRAC_W];
	assign below      = raw < RAW_W'(limit_low);
	assign above      = raw > RAW_W'(limit_high);
	// Low limit takes priority when the limits are inverted
	assign clamp      = below || above;
	assign lim_sel    = below ? limit_low : limit_high;
	assign lim_scaled = {lim_sel, {FRAC_W{1'b0}}};
	assign back_calc  = PD_W'(lim_scaled) - pd_s2;
	assign integ_next = (clamp && gain_i != '0) ? back_calc[INTEG_W-1:0] : integ_acc;
	assign load3      = v2_q && rdy3 && run_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			drive_q    <= '0;
			at_limit_q <= 1'b0;
		end else if (load3) begin
			integ_q    <= integ_next;
			drive_q    <= clamp ? lim_sel : raw[DATA_W-1:0];
			at_limit_q <= clamp;
		end
	end

	assign drive    = drive_q;
	assign at_limit = at_limit_q;

`ifndef ASSERT_OFF
	// A clamped result must sit on one of the limits
	a_limit_value: assert property (@(posedge clk) disable iff (!arst_n)
		load3 && clamp |=> drive == limit_low || drive == limit_high)
		else $error("clamped drive not on a limit");

	// Integrator holds unless a running item leaves stage 3
	a_integ_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load3 |=> $stable(integ_q))
		else $error("integrator moved without a running item");

	// Previous error holds unless a running item is accepted
	a_prev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc_in && run) |=> $stable(prev_q))
		else $error("previous error moved without a running item");

	// Held result only changes when a running item completes
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load3 |=> $stable(drive_q) && $stable(at_limit_q))
		else $error("held result changed without a running item");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for pid_clamped_back_calc: a directed run, then random phases with register changes.
// A scoreboard class predicts drive and at_limit from each accepted item; plain tasks drive the ports.
// Depends on pcbc_pkg and the design under test.
module tb_top;
	import pcbc_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic                     at_limit;
	} drive_result_t;

	class pid_drive_predictor;
		logic signed [DATA_W-1:0]  k_p, k_i, k_d, lim_lo, lim_hi;
		logic signed [INTEG_W-1:0] preset;
		logic signed [INTEG_W-1:0] integ;
		logic signed [DATA_W-1:0]  prev_err, hold_drive;
		logic                      hold_limit;
		drive_result_t             expected_drives[$];
		int                        mismatches;

		function new();
			k_p = '0; k_i = '0; k_d = '0;
			lim_lo = LIMIT_LOW_RST;
			lim_hi = LIMIT_HIGH_RST;
			preset = '0;
			integ = '0;
			prev_err = '0;
			hold_drive = '0;
			hold_limit = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(pcbc_reg_t idx, logic [31:0] val);
			case (idx)
				REG_GAIN_P:       k_p = val[DATA_W-1:0];
				REG_GAIN_I:       k_i = val[DATA_W-1:0];
				REG_GAIN_D:       k_d = val[DATA_W-1:0];
				REG_LIMIT_LOW:    lim_lo = val[DATA_W-1:0];
				REG_LIMIT_HIGH:   lim_hi = val[DATA_W-1:0];
				REG_INTEG_PRESET: preset = val[INTEG_W-1:0];
				default:          ;
			endcase
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction

		function void note_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] mv,
				logic go, logic rs);
			logic signed [DATA_W-1:0] err;
			longint half, pd, raw, tmp;
			drive_result_t r;
			if (go) begin
				if (rs) begin
					integ = preset;
					prev_err = '0;
				end
				err = sp - mv;
				half = (longint'(err) + longint'(prev_err)) >>> 1;
				tmp = longint'(integ) + longint'(k_i) * half;
				integ = tmp[INTEG_W-1:0];
				pd = longint'(k_p) * longint'(err)
					+ longint'(k_d) * (longint'(err) - longint'(prev_err));
				raw = (pd + longint'(integ)) >>> FRAC_W;
				hold_limit = 1'b0;
				hold_drive = raw[DATA_W-1:0];
				// low test wins when the limits are inverted
				if (raw < longint'(lim_lo)) begin
					hold_limit = 1'b1;
					if (k_i != 0) begin
						tmp = longint'(lim_lo) * 256 - pd;
						integ = tmp[INTEG_W-1:0];
					end
					hold_drive = lim_lo;
				end else if (raw > longint'(lim_hi)) begin
					hold_limit = 1'b1;
					if (k_i != 0) begin
						tmp = longint'(lim_hi) * 256 - pd;
						integ = tmp[INTEG_W-1:0];
					end
					hold_drive = lim_hi;
				end
				prev_err = err;
			end
			r.drive = hold_drive;
			r.at_limit = hold_limit;
			expected_drives.push_back(r);
		endfunction

		task report(string msg);
			if (mismatches < 100)
				$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_drive(logic signed [DATA_W-1:0] drv, logic lim);
			drive_result_t r;
			if (expected_drives.size() == 0) begin
				report($sformatf("result drive=%0d at_limit=%b with nothing expected", drv, lim));
			end else begin
				r = expected_drives.pop_front();
				if (drv !== r.drive)
					report($sformatf("drive %0d, expected %0d", drv, r.drive));
				if (lim !== r.at_limit)
					report($sformatf("at_limit %b, expected %b", lim, r.at_limit));
			end
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [31:0]              pwdata = '0;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] setpoint = '0, measured = '0;
	logic                     run = 1'b0, restart = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] drive;
	logic                     at_limit;

	bit calm = 1'b0;
	bit long_hold = 1'b0;

	pid_drive_predictor predictor = new();

	pid_clamped_back_calc dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.setpoint(setpoint), .measured(measured), .run(run), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.drive(drive), .at_limit(at_limit)
	);

	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("tb_top: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			predictor.check_drive(drive, at_limit);
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		int stall_left;
		int hold_cnt;
		stall_left = 0;
		hold_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready = 1'b0;
				hold_cnt++;
				if (hold_cnt == 80) begin
					long_hold = 1'b0;
					hold_cnt = 0;
				end
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				stall_left = $urandom_range(1, 9) - 1;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	task write_reg(pcbc_reg_t idx, logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		predictor.set_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task write_all(logic signed [15:0] gp, logic signed [15:0] gi, logic signed [15:0] gd,
			logic signed [15:0] lo, logic signed [15:0] hi, logic [31:0] pre);
		write_reg(REG_GAIN_P, 32'(gp));
		write_reg(REG_GAIN_I, 32'(gi));
		write_reg(REG_GAIN_D, 32'(gd));
		write_reg(REG_LIMIT_LOW, 32'(lo));
		write_reg(REG_LIMIT_HIGH, 32'(hi));
		write_reg(REG_INTEG_PRESET, pre);
	endtask

	// called and returns at a falling edge
	task send_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] mv,
			logic go, logic rs);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		setpoint = sp;
		measured = mv;
		run = go;
		restart = rs;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predictor.note_sample(sp, mv, go, rs);
		@(negedge clk);
	endtask

	// drop valid and let the pipeline empty before touching registers
	task drain();
		in_valid = 1'b0;
		while (predictor.pending() > 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic signed [15:0] near_zero(int span);
		return 16'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task apply_phase(int ph);
		logic signed [15:0] a, b;
		case (ph)
			0: write_all(256, 32, 64, -4000, 4000, 32'd0);
			1: write_all(32767, 32767, 32767, -32768, 32767, 32'h7fff_ffff);
			2: write_all(-32768, -32768, -32768, -32768, 32767, 32'h8000_0000);
			3: write_all(512, 0, -300, -500, 500, $urandom);
			4: write_all(200, 10, 50, 300, -300, 32'd5000);
			5: write_all(100, -20, 0, 7, 7, 32'hffff_f000);
			default: begin
				a = 16'($urandom);
				b = 16'($urandom);
				if (a > b) write_all(near_zero(1024), near_zero(128), near_zero(512), b, a, $urandom);
				else write_all(near_zero(1024), near_zero(128), near_zero(512), a, b, $urandom);
			end
		endcase
	endtask

	initial begin
		logic signed [DATA_W-1:0] sp, mv;
		logic                     go, rs;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_all(256, 64, 128, -2000, 2000, 32'd1000);
		send_sample(0, 0, 1, 1);
		send_sample(32767, -32768, 1, 0);
		send_sample(-32768, 32767, 1, 0);
		send_sample(-3, 0, 1, 0);
		send_sample(0, 4, 1, 0);
		send_sample(5, -2, 0, 1);
		send_sample(5, -2, 0, 0);
		send_sample(32767, 0, 1, 0);
		send_sample(32767, 0, 1, 0);
		send_sample(-32768, 0, 1, 0);
		send_sample(-32768, 0, 1, 0);
		send_sample(0, 32767, 1, 1);
		send_sample(100, 100, 1, 0);
		send_sample(1, 0, 1, 0);
		send_sample(-1, 0, 1, 0);
		send_sample(0, -32768, 1, 0);
		send_sample(-1, 32767, 1, 0);
		send_sample(12, 3, 1, 1);
		send_sample(0, 0, 0, 0);
		send_sample(20000, -20000, 1, 0);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			apply_phase(ph);
			for (int n = 0; n < 200; n++) begin
				if (ph == 5 && n == 50)
					long_hold = 1'b1;
				if (ph == 7 && n == 100)
					calm = 1'b1;
				if ($urandom_range(0, 3) == 0) sp = 16'($urandom);
				else sp = near_zero(1024);
				case ($urandom_range(0, 3))
					0:       mv = 16'($urandom);
					1:       mv = sp + near_zero(16);
					default: mv = near_zero(1024);
				endcase
				go = ($urandom_range(0, 9) != 0);
				rs = ($urandom_range(0, 19) == 0);
				send_sample(sp, mv, go, rs);
			end
		end

		in_valid = 1'b0;
		while (predictor.pending() > 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (predictor.mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
